// ===== src/tnt_pkg.sv =====
`default_nettype none
package tnt_pkg;

    // multiplier digit width: one operand is consumed this many bits per cycle
    localparam int MUL_CHUNK  = 16;
    // quotient bits produced by the divider
    localparam int DIV_QBITS  = 32;
    // normal magnitudes are brought below 2^NORM_BITS before squaring
    localparam int NORM_BITS  = 30;
    localparam int NORM_SHIFT = 14;
    localparam int TAN_SHIFT  = 16;
    localparam logic [15:0] NORM_MAX = 16'h7FFF;
    localparam logic [31:0] TAN_POS_LIM = 32'h7FFF_FFFF;
    localparam logic [31:0] TAN_NEG_LIM = 32'h8000_0000;

    typedef struct packed {
        logic start;
        logic done;
    } unit_ctl_t;

endpackage
`default_nettype wire

// ===== src/tnt_mul.sv =====
`default_nettype none
module tnt_mul #(
    parameter int W = 33
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic signed [W-1:0]     op_a,
    input  wire logic signed [W-1:0]     op_b,
    output logic                         done,
    output logic signed [2*W-1:0]        prod
);
    import tnt_pkg::*;

    localparam int NCH = (W + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int BW  = NCH * MUL_CHUNK;
    localparam int AW  = BW + W;
    localparam int CNTW = $clog2(NCH + 1);

    logic [W-1:0]    amag_reg;
    logic [BW-1:0]   bsh_reg;
    logic [AW-1:0]   acc_reg;
    logic            neg_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;

    logic [W-1:0]         amag;
    logic [W-1:0]         bmag;
    logic [MUL_CHUNK-1:0] chunk;
    logic [AW-1:0]        acc_next;
    logic [2*W-1:0]       mag;

    assign amag  = op_a[W-1] ? W'(-op_a) : W'(op_a);
    assign bmag  = op_b[W-1] ? W'(-op_b) : W'(op_b);
    assign chunk = bsh_reg[BW-1 -: MUL_CHUNK];
    // shift-accumulate, most significant digit first
    assign acc_next = (acc_reg << MUL_CHUNK) + AW'(amag_reg) * AW'(chunk);
    assign mag  = acc_reg[2*W-1:0];
    assign prod = neg_reg ? $signed(-mag) : $signed(mag);
    assign done = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(NCH);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            amag_reg <= amag;
            bsh_reg  <= BW'(bmag);
            acc_reg  <= '0;
            neg_reg  <= op_a[W-1] ^ op_b[W-1];
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            bsh_reg <= bsh_reg << MUL_CHUNK;
        end
    end

endmodule
`default_nettype wire

// ===== src/tnt_div.sv =====
`default_nettype none
module tnt_div #(
    parameter int NUMW = 79,
    parameter int DENW = 63
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               start,
    input  wire logic [NUMW-1:0]                    num,
    input  wire logic [DENW-1:0]                    den,
    output logic                                    done,
    output logic                                    ovf,
    output logic [tnt_pkg::DIV_QBITS-1:0]           quo
);
    import tnt_pkg::*;

    localparam int CMPW = DENW + DIV_QBITS;
    localparam int CNTW = $clog2(DIV_QBITS + 1);

    logic [DENW-1:0]      rem_reg;
    logic [DENW-1:0]      den_reg;
    logic [DIV_QBITS-1:0] low_reg;
    logic                 ovf_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [CNTW-1:0]      cnt_reg;

    logic            too_big;
    logic [DENW:0]   trial;
    logic            ge;

    // quotient would need more than DIV_QBITS bits
    assign too_big = CMPW'(num) >= (CMPW'(den) << DIV_QBITS);
    assign trial   = {rem_reg, low_reg[DIV_QBITS-1]};
    assign ge      = trial >= {1'b0, den_reg};
    assign done = done_reg;
    assign ovf  = ovf_reg;
    assign quo  = low_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= !too_big;
                done_reg <= too_big;
                cnt_reg  <= CNTW'(DIV_QBITS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            ovf_reg <= too_big;
            rem_reg <= DENW'(num >> DIV_QBITS);
            low_reg <= num[DIV_QBITS-1:0];
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= ge ? DENW'(trial - {1'b0, den_reg}) : DENW'(trial);
            low_reg <= {low_reg[DIV_QBITS-2:0], ge};
        end
    end

endmodule
`default_nettype wire

// ===== src/triangle_normal_tangent.sv =====
`default_nettype none
// Triangle face normal and tangent. Corners arrive one per request; corners 0 and 1
// are held, corner 3 is dropped, and corner 2 starts the computation of one result:
// the unit face normal (Q2.14, zero plus a flag for a degenerate triangle) and the
// tangent (Q16.16, truncated toward zero and saturated, zero plus a flag for a zero
// texture determinant). Corner 2 is worked through one shared chunked multiplier
// (NCH = ceil(MW/16) digits of 16 bits, MW = max(COORD_WIDTH+1, 31)), a restoring
// divider that stops early on overflow and a bit-pair square root. Before squaring,
// a one-bit-per-cycle shift brings the cross product below 2^30. The normal steps
// are skipped for a degenerate normal and the tangent divisions for a zero
// determinant. Input is not taken while corner 2 is worked on; a finished result
// waits in the output register while the next corners are accepted.
module triangle_normal_tangent #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_corner,
    input  wire logic signed [31:0] s_pos_x,
    input  wire logic signed [31:0] s_pos_y,
    input  wire logic signed [31:0] s_pos_z,
    input  wire logic signed [31:0] s_tex_u,
    input  wire logic signed [31:0] s_tex_v,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_normal_x,
    output logic signed [15:0]      m_normal_y,
    output logic signed [15:0]      m_normal_z,
    output logic signed [31:0]      m_tangent_x,
    output logic signed [31:0]      m_tangent_y,
    output logic signed [31:0]      m_tangent_z,
    output logic                    m_normal_degenerate,
    output logic                    m_tangent_invalid
);
    import tnt_pkg::*;

    localparam int DW   = COORD_WIDTH + 1;
    localparam int LW   = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam bit SGN  = (COORD_WIDTH <= 32);
    localparam int MW   = (DW > NORM_BITS + 1) ? DW : NORM_BITS + 1;
    localparam int XW   = 2 * MW + 1;
    localparam int DNW  = XW + TAN_SHIFT;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_MUL_GO    = 4'd1;
    localparam logic [3:0] ST_MUL_WAIT  = 4'd2;
    localparam logic [3:0] ST_NCHK      = 4'd3;
    localparam logic [3:0] ST_SHIFT     = 4'd4;
    localparam logic [3:0] ST_SQ_GO     = 4'd5;
    localparam logic [3:0] ST_SQ_WAIT   = 4'd6;
    localparam logic [3:0] ST_SQRT      = 4'd7;
    localparam logic [3:0] ST_NDIV_GO   = 4'd8;
    localparam logic [3:0] ST_NDIV_WAIT = 4'd9;
    localparam logic [3:0] ST_TCHK      = 4'd10;
    localparam logic [3:0] ST_TDIV_GO   = 4'd11;
    localparam logic [3:0] ST_TDIV_WAIT = 4'd12;
    localparam logic [3:0] ST_DONE      = 4'd13;

    localparam logic [2:0] K_DET  = 3'd3;
    localparam logic [2:0] K_TAN0 = 3'd4;
    localparam logic [2:0] K_LAST = 3'd6;

    function automatic logic signed [DW-1:0] coord(input logic [31:0] raw);
        coord = $signed({{(DW - LW){SGN & raw[LW-1]}}, raw[LW-1:0]});
    endfunction

    function automatic logic [XW-1:0] xabs(input logic signed [XW-1:0] v);
        xabs = v[XW-1] ? XW'(-v) : XW'(v);
    endfunction

    logic [3:0]  state_reg;
    logic [31:0] hp_reg [6];
    logic [31:0] ht_reg [4];
    logic [31:0] p2_reg [3];
    logic [31:0] t2_reg [2];
    logic [2:0]  k_reg;
    logic        half_reg;
    logic [1:0]  j_reg;
    logic signed [2*MW-1:0] tmp_reg;
    logic signed [XW-1:0]   xr_reg [7];
    logic [XW-1:0]          nm_reg [3];
    logic [63:0] len2_reg, sx_reg, sr_reg, sb_reg;
    logic [31:0] len_reg;
    logic [15:0] nres_reg [3];
    logic [31:0] tres_reg [3];
    logic        ndeg_reg, tinv_reg;
    logic        m_valid_reg;
    logic [15:0] m_nrm_reg [3];
    logic [31:0] m_tan_reg [3];
    logic        m_ndeg_reg, m_tinv_reg;

    logic signed [DW-1:0] e1 [3];
    logic signed [DW-1:0] e2 [3];
    logic signed [DW-1:0] du1, dv1, du2, dv2;
    logic signed [MW-1:0] ma, mb;
    logic signed [2*MW-1:0] mul_prod;
    logic [NORM_BITS:0]   sq_op;
    logic signed [XW-1:0] cross_val;
    logic [XW-1:0]        or_mag;
    logic [63:0]          sq_sum;
    logic signed [XW-1:0] tn_sel;
    logic [DNW-1:0]       div_num;
    logic [XW-1:0]        div_den;
    logic                 div_ovf;
    logic [DIV_QBITS-1:0] div_quo;
    logic                 t_neg;
    logic [31:0]          t_lim, t_mag;
    logic [15:0]          n_mag;
    unit_ctl_t            mul_ctl, div_ctl;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e1[i] = coord(hp_reg[3 + i]) - coord(hp_reg[i]);
            e2[i] = coord(p2_reg[i]) - coord(hp_reg[i]);
        end
    end
    assign du1 = coord(ht_reg[2]) - coord(ht_reg[0]);
    assign dv1 = coord(ht_reg[3]) - coord(ht_reg[1]);
    assign du2 = coord(t2_reg[0]) - coord(ht_reg[0]);
    assign dv2 = coord(t2_reg[1]) - coord(ht_reg[1]);

    assign sq_op = {1'b0, nm_reg[j_reg][NORM_BITS-1:0]};

    // operand select: squares in ST_SQ_GO; otherwise each cross term is a*b - c*d, first half then second half
    always_comb begin
        ma = '0;
        mb = '0;
        if (state_reg == ST_SQ_GO) begin
            ma = MW'($signed(sq_op));
            mb = MW'($signed(sq_op));
        end else begin
            case (k_reg)
                3'd0: begin
                    ma = MW'(half_reg ? e1[2] : e1[1]);
                    mb = MW'(half_reg ? e2[1] : e2[2]);
                end
                3'd1: begin
                    ma = MW'(half_reg ? e1[0] : e1[2]);
                    mb = MW'(half_reg ? e2[2] : e2[0]);
                end
                3'd2: begin
                    ma = MW'(half_reg ? e1[1] : e1[0]);
                    mb = MW'(half_reg ? e2[0] : e2[1]);
                end
                3'd3: begin
                    ma = MW'(half_reg ? du2 : du1);
                    mb = MW'(half_reg ? dv1 : dv2);
                end
                3'd4: begin
                    ma = MW'(half_reg ? dv1 : dv2);
                    mb = MW'(half_reg ? e2[0] : e1[0]);
                end
                3'd5: begin
                    ma = MW'(half_reg ? dv1 : dv2);
                    mb = MW'(half_reg ? e2[1] : e1[1]);
                end
                3'd6: begin
                    ma = MW'(half_reg ? dv1 : dv2);
                    mb = MW'(half_reg ? e2[2] : e1[2]);
                end
                default: begin
                    ma = '0;
                    mb = '0;
                end
            endcase
        end
    end

    assign mul_ctl.start = (state_reg == ST_MUL_GO) || (state_reg == ST_SQ_GO);
    assign div_ctl.start = (state_reg == ST_NDIV_GO) || (state_reg == ST_TDIV_GO);

    tnt_mul #(.W(MW)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_ctl.start),
        .op_a    (ma),
        .op_b    (mb),
        .done    (mul_ctl.done),
        .prod    (mul_prod)
    );

    assign tn_sel = xr_reg[K_TAN0 + 3'(j_reg)];

    always_comb begin
        if (state_reg == ST_NDIV_GO) begin
            div_num = (DNW'(nm_reg[j_reg][NORM_BITS-1:0]) << NORM_SHIFT)
                      + DNW'(len_reg[31:1]);
            div_den = XW'(len_reg);
        end else begin
            div_num = DNW'(xabs(tn_sel)) << TAN_SHIFT;
            div_den = xabs(xr_reg[K_DET]);
        end
    end

    tnt_div #(.NUMW(DNW), .DENW(XW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_ctl.start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_ctl.done),
        .ovf     (div_ovf),
        .quo     (div_quo)
    );

    assign cross_val = XW'(tmp_reg) - XW'(mul_prod);
    assign or_mag    = nm_reg[0] | nm_reg[1] | nm_reg[2];
    assign sq_sum    = sr_reg + sb_reg;
    assign n_mag     = (div_ovf || div_quo > 32'(NORM_MAX)) ? NORM_MAX : div_quo[15:0];
    assign t_neg     = tn_sel[XW-1] ^ xr_reg[K_DET][XW-1];
    assign t_lim     = t_neg ? TAN_NEG_LIM : TAN_POS_LIM;
    assign t_mag     = (div_ovf || div_quo > t_lim) ? t_lim : div_quo;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_normal_x  = $signed(m_nrm_reg[0]);
    assign m_normal_y  = $signed(m_nrm_reg[1]);
    assign m_normal_z  = $signed(m_nrm_reg[2]);
    assign m_tangent_x = $signed(m_tan_reg[0]);
    assign m_tangent_y = $signed(m_tan_reg[1]);
    assign m_tangent_z = $signed(m_tan_reg[2]);
    assign m_normal_degenerate = m_ndeg_reg;
    assign m_tangent_invalid   = m_tinv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            k_reg       <= '0;
            half_reg    <= 1'b0;
            j_reg       <= '0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_corner == 2'd2) begin
                        k_reg     <= '0;
                        half_reg  <= 1'b0;
                        state_reg <= ST_MUL_GO;
                    end
                end
                ST_MUL_GO: begin
                    state_reg <= ST_MUL_WAIT;
                end
                ST_MUL_WAIT: begin
                    if (mul_ctl.done) begin
                        if (!half_reg) begin
                            half_reg <= 1'b1;
                            state_reg <= ST_MUL_GO;
                        end else begin
                            half_reg <= 1'b0;
                            k_reg    <= k_reg + 1'b1;
                            state_reg <= (k_reg == K_LAST) ? ST_NCHK : ST_MUL_GO;
                        end
                    end
                end
                ST_NCHK: begin
                    j_reg <= '0;
                    if (xr_reg[0] == '0 && xr_reg[1] == '0 && xr_reg[2] == '0) begin
                        state_reg <= ST_TCHK;
                    end else begin
                        state_reg <= ST_SHIFT;
                    end
                end
                ST_SHIFT: begin
                    if ((or_mag >> NORM_BITS) == '0) begin
                        state_reg <= ST_SQ_GO;
                    end
                end
                ST_SQ_GO: begin
                    state_reg <= ST_SQ_WAIT;
                end
                ST_SQ_WAIT: begin
                    if (mul_ctl.done) begin
                        j_reg <= (j_reg == 2'd2) ? 2'd0 : j_reg + 1'b1;
                        state_reg <= (j_reg == 2'd2) ? ST_SQRT : ST_SQ_GO;
                    end
                end
                ST_SQRT: begin
                    if (sb_reg == '0) begin
                        state_reg <= ST_NDIV_GO;
                    end
                end
                ST_NDIV_GO: begin
                    state_reg <= ST_NDIV_WAIT;
                end
                ST_NDIV_WAIT: begin
                    if (div_ctl.done) begin
                        j_reg <= (j_reg == 2'd2) ? 2'd0 : j_reg + 1'b1;
                        state_reg <= (j_reg == 2'd2) ? ST_TCHK : ST_NDIV_GO;
                    end
                end
                ST_TCHK: begin
                    j_reg <= '0;
                    state_reg <= (xr_reg[K_DET] == '0) ? ST_DONE : ST_TDIV_GO;
                end
                ST_TDIV_GO: begin
                    state_reg <= ST_TDIV_WAIT;
                end
                ST_TDIV_WAIT: begin
                    if (div_ctl.done) begin
                        j_reg <= (j_reg == 2'd2) ? 2'd0 : j_reg + 1'b1;
                        state_reg <= (j_reg == 2'd2) ? ST_DONE : ST_TDIV_GO;
                    end
                end
                ST_DONE: begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_corner == 2'd0 || s_corner == 2'd1) begin
                        hp_reg[3'(3 * s_corner[0])]     <= s_pos_x;
                        hp_reg[3'(3 * s_corner[0] + 1)] <= s_pos_y;
                        hp_reg[3'(3 * s_corner[0] + 2)] <= s_pos_z;
                        ht_reg[2'(2 * s_corner[0])]     <= s_tex_u;
                        ht_reg[2'(2 * s_corner[0] + 1)] <= s_tex_v;
                    end else if (s_corner == 2'd2) begin
                        p2_reg[0] <= s_pos_x;
                        p2_reg[1] <= s_pos_y;
                        p2_reg[2] <= s_pos_z;
                        t2_reg[0] <= s_tex_u;
                        t2_reg[1] <= s_tex_v;
                    end
                end
            end
            ST_MUL_WAIT: begin
                if (mul_ctl.done) begin
                    if (!half_reg) begin
                        tmp_reg <= mul_prod;
                    end else begin
                        xr_reg[k_reg] <= cross_val;
                    end
                end
            end
            ST_NCHK: begin
                len2_reg <= '0;
                if (xr_reg[0] == '0 && xr_reg[1] == '0 && xr_reg[2] == '0) begin
                    ndeg_reg <= 1'b1;
                    for (int i = 0; i < 3; i++) nres_reg[i] <= '0;
                end else begin
                    ndeg_reg <= 1'b0;
                    for (int i = 0; i < 3; i++) nm_reg[i] <= xabs(xr_reg[i]);
                end
            end
            ST_SHIFT: begin
                if ((or_mag >> NORM_BITS) != '0) begin
                    for (int i = 0; i < 3; i++) nm_reg[i] <= nm_reg[i] >> 1;
                end
            end
            ST_SQ_WAIT: begin
                if (mul_ctl.done) begin
                    len2_reg <= len2_reg + 64'(mul_prod);
                    if (j_reg == 2'd2) begin
                        sx_reg <= len2_reg + 64'(mul_prod);
                        sr_reg <= '0;
                        sb_reg <= 64'h4000_0000_0000_0000;
                    end
                end
            end
            ST_SQRT: begin
                if (sb_reg != '0) begin
                    if (sx_reg >= sq_sum) begin
                        sx_reg <= sx_reg - sq_sum;
                        sr_reg <= (sr_reg >> 1) + sb_reg;
                    end else begin
                        sr_reg <= sr_reg >> 1;
                    end
                    sb_reg <= sb_reg >> 2;
                end else begin
                    len_reg <= (sr_reg == '0) ? 32'd1 : sr_reg[31:0];
                end
            end
            ST_NDIV_WAIT: begin
                if (div_ctl.done) begin
                    nres_reg[j_reg] <= xr_reg[j_reg][XW-1] ? 16'(-n_mag) : n_mag;
                end
            end
            ST_TCHK: begin
                if (xr_reg[K_DET] == '0) begin
                    tinv_reg <= 1'b1;
                    for (int i = 0; i < 3; i++) tres_reg[i] <= '0;
                end else begin
                    tinv_reg <= 1'b0;
                end
            end
            ST_TDIV_WAIT: begin
                if (div_ctl.done) begin
                    tres_reg[j_reg] <= t_neg ? 32'(-t_mag) : t_mag;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    for (int i = 0; i < 3; i++) begin
                        m_nrm_reg[i] <= nres_reg[i];
                        m_tan_reg[i] <= tres_reg[i];
                    end
                    m_ndeg_reg <= ndeg_reg;
                    m_tinv_reg <= tinv_reg;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire
